@@ design/rect_non_overlap_propagator_core_defines.svh @@
// Assertion macros for the rectangle non-overlap propagator checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef RECT_NON_OVERLAP_PROPAGATOR_CORE_DEFINES_SVH
`define RECT_NON_OVERLAP_PROPAGATOR_CORE_DEFINES_SVH

// Property that holds at every edge outside reset.
`define RNOP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rnop: assertion failed");

// Implication checked from the next edge on.
`define RNOP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnop: assertion failed");

`endif

@@ design/rnop_pkg.sv @@
// Shared types and constants of the rectangle non-overlap propagator.
// No dependencies.
package rnop_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_BOXES);
  localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_PROP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  // unused code, acts as read
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  localparam logic CFG_STRICT = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  // one-hot relative placement codes of the push rule
  localparam logic [3:0] DIR_NONE  = 4'b0000;
  localparam logic [3:0] DIR_LEFT  = 4'b0001;
  localparam logic [3:0] DIR_RIGHT = 4'b0010;
  localparam logic [3:0] DIR_BELOW = 4'b0100;
  localparam logic [3:0] DIR_ABOVE = 4'b1000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t xl;
    coord_t xh;
    coord_t wl;
    coord_t wh;
    coord_t yl;
    coord_t yh;
    coord_t hl;
    coord_t hh;
  } box_t;

  localparam int BOX_BITS = $bits(box_t);

  typedef struct packed {
    coord_t pl;
    coord_t ph;
    coord_t sl;
    coord_t sh;
  } axis_t;

  typedef struct packed {
    axis_t p;
    axis_t q;
    logic  ok;
  } ax_res_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  box_index;
    logic [15:0] in_x_lo;
    logic [15:0] in_x_hi;
    logic [15:0] in_w_lo;
    logic [15:0] in_w_hi;
    logic [15:0] in_y_lo;
    logic [15:0] in_y_hi;
    logic [15:0] in_h_lo;
    logic [15:0] in_h_hi;
  } in_req_t;

  typedef struct packed {
    logic        failed;
    logic [15:0] out_x_lo;
    logic [15:0] out_x_hi;
    logic [15:0] out_w_lo;
    logic [15:0] out_w_hi;
    logic [15:0] out_y_lo;
    logic [15:0] out_y_hi;
    logic [15:0] out_h_lo;
    logic [15:0] out_h_hi;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LATCH,
    ST_GATHER,
    ST_E_INIT,
    ST_E_SUM,
    ST_E_LIST,
    ST_E_TAB,
    ST_E_UPD,
    ST_E_MUL,
    ST_E_CMP,
    ST_P_LIST,
    ST_P_TAB,
    ST_P_ACT,
    ST_WB,
    ST_DONE
  } state_t;

endpackage

@@ design/rect_non_overlap_propagator_core.sv @@
// Rectangle non-overlap propagator. Load writes the bounds table and read
// fetches an entry; both answer through the result register. Propagate of
// box b makes one pass over the boxes in use in the bounds memory to gather
// neighbors (one entry a cycle), then runs the area check per neighbor
// (E_LIST, E_TAB, E_UPD, E_MUL, E_CMP: two chained memory reads, two multiplies)
// and the push per neighbor (P_LIST, P_TAB, P_ACT). The bounds table and the
// neighbor list live in one-write one-read synchronous RAMs with no clearing
// pass; box b is held in registers during the request and written back at its end.
// Uses rnop_pkg, rnop_ram, rnop_push.
module rect_non_overlap_propagator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rnop_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rnop_pkg::out_rsp_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  localparam int IW = rnop_pkg::IDX_BITS;
  localparam int NW = rnop_pkg::CNT_BITS;
  localparam int CB = rnop_pkg::COORD_BITS;
  localparam int AB = 2 * CB;
  localparam int SB = AB + IW + 1;

  function automatic logic overlap(rnop_pkg::box_t a, rnop_pkg::box_t b, logic strict);
    logic ax, ay;
    ax = ({1'b0, a.xl} >= {1'b0, b.xh} + {1'b0, b.wh}) ||
         ({1'b0, b.xl} >= {1'b0, a.xh} + {1'b0, a.wh}) ||
         (!strict && (a.wl == '0 || b.wl == '0));
    ay = ({1'b0, a.yl} >= {1'b0, b.yh} + {1'b0, b.hh}) ||
         ({1'b0, b.yl} >= {1'b0, a.yh} + {1'b0, a.hh}) ||
         (!strict && (a.hl == '0 || b.hl == '0));
    return !ax && !ay;
  endfunction

  rnop_pkg::state_t state_r, state_nxt;

  logic          strict_r;
  logic [NW-1:0] count_r, used;
  logic [IW-1:0] idx_r, oidx_r;
  logic          prop_r, fail_r;
  rnop_pkg::box_t bbox_r;
  logic [NW-1:0] k_r, total_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_k_r;
  logic [CB-1:0] lx_r, ly_r;
  logic [CB:0]   hx_r, hy_r;
  logic [AB-1:0] area_r;
  logic [SB-1:0] sum_r;
  logic signed [2*CB+3:0] prod_r;
  logic          out_valid_r;
  rnop_pkg::out_rsp_t out_r;

  logic          tbl_we, tbl_re, lst_we, lst_re;
  logic [IW-1:0] tbl_wa, tbl_ra, lst_wa, lst_ra, lst_rd;
  rnop_pkg::box_t tbl_wd, tbl_rd, o_rd, b_new, o_new, in_box;
  logic          push_ok, accept, out_free, gather_hit, last_nb;
  logic [CB:0]   o_hx, o_hy;
  logic signed [CB+1:0] dx, dy;

  assign used = (count_r > NW'(rnop_pkg::MAX_BOXES)) ? NW'(rnop_pkg::MAX_BOXES) : count_r;
  assign in_stall  = (state_r != rnop_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign o_rd      = tbl_rd;
  assign gather_hit = chk_v_r && (chk_k_r != idx_r) && overlap(tbl_rd, bbox_r, strict_r);
  assign last_nb   = (k_r + NW'(1)) == total_r;
  assign o_hx = {1'b0, o_rd.xh} + {1'b0, o_rd.wh};
  assign o_hy = {1'b0, o_rd.yh} + {1'b0, o_rd.hh};
  assign dx = $signed({1'b0, hx_r}) - $signed({2'b00, lx_r});
  assign dy = $signed({1'b0, hy_r}) - $signed({2'b00, ly_r});

  assign in_box = '{xl: in_data.in_x_lo, xh: in_data.in_x_hi,
                    wl: in_data.in_w_lo, wh: in_data.in_w_hi,
                    yl: in_data.in_y_lo, yh: in_data.in_y_hi,
                    hl: in_data.in_h_lo, hh: in_data.in_h_hi};

  rnop_ram #(.WIDTH(rnop_pkg::BOX_BITS), .DEPTH(rnop_pkg::MAX_BOXES)) u_tbl (
    .clk(clk), .we(tbl_we), .wa(tbl_wa), .wd(tbl_wd),
    .re(tbl_re), .ra(tbl_ra), .rd(tbl_rd)
  );

  rnop_ram #(.WIDTH(IW), .DEPTH(rnop_pkg::MAX_BOXES)) u_lst (
    .clk(clk), .we(lst_we), .wa(lst_wa), .wd(chk_k_r),
    .re(lst_re), .ra(lst_ra), .rd(lst_rd)
  );

  rnop_push u_push (
    .b_box(bbox_r), .o_box(o_rd), .b_new(b_new), .o_new(o_new), .ok(push_ok)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnop_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.func == rnop_pkg::FUNC_LOAD) ? rnop_pkg::ST_DONE
                                                            : rnop_pkg::ST_LATCH;
        end
      end
      rnop_pkg::ST_LATCH:  state_nxt = prop_r ? rnop_pkg::ST_GATHER : rnop_pkg::ST_DONE;
      rnop_pkg::ST_GATHER: begin
        if (k_r == used && !chk_v_r) state_nxt = rnop_pkg::ST_E_INIT;
      end
      rnop_pkg::ST_E_INIT: state_nxt = rnop_pkg::ST_E_SUM;
      rnop_pkg::ST_E_SUM:  begin
        state_nxt = (total_r == '0) ? rnop_pkg::ST_WB : rnop_pkg::ST_E_LIST;
      end
      rnop_pkg::ST_E_LIST: state_nxt = rnop_pkg::ST_E_TAB;
      rnop_pkg::ST_E_TAB:  state_nxt = rnop_pkg::ST_E_UPD;
      rnop_pkg::ST_E_UPD:  state_nxt = rnop_pkg::ST_E_MUL;
      rnop_pkg::ST_E_MUL:  state_nxt = rnop_pkg::ST_E_CMP;
      rnop_pkg::ST_E_CMP:  begin
        if ($signed({1'b0, sum_r}) > SB'(prod_r) + (SB+1)'(0)) state_nxt = rnop_pkg::ST_WB;
        else if (last_nb) state_nxt = rnop_pkg::ST_P_LIST;
        else state_nxt = rnop_pkg::ST_E_LIST;
      end
      rnop_pkg::ST_P_LIST: state_nxt = rnop_pkg::ST_P_TAB;
      rnop_pkg::ST_P_TAB:  state_nxt = rnop_pkg::ST_P_ACT;
      rnop_pkg::ST_P_ACT:  begin
        state_nxt = (!push_ok || last_nb) ? rnop_pkg::ST_WB : rnop_pkg::ST_P_LIST;
      end
      rnop_pkg::ST_WB:     state_nxt = rnop_pkg::ST_DONE;
      rnop_pkg::ST_DONE:   begin
        if (out_free) state_nxt = rnop_pkg::ST_IDLE;
      end
      default:             state_nxt = rnop_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = idx_r;
    tbl_wd = bbox_r;
    tbl_re = 1'b0;
    tbl_ra = k_r[IW-1:0];
    lst_we = 1'b0;
    lst_wa = total_r[IW-1:0];
    lst_re = 1'b0;
    lst_ra = k_r[IW-1:0];
    case (state_r)
      rnop_pkg::ST_IDLE: begin
        tbl_wa = in_data.box_index;
        tbl_wd = in_box;
        tbl_ra = in_data.box_index;
        tbl_we = accept && (in_data.func == rnop_pkg::FUNC_LOAD);
        tbl_re = accept && (in_data.func != rnop_pkg::FUNC_LOAD);
      end
      rnop_pkg::ST_GATHER: begin
        tbl_re = (k_r < used);
        lst_we = gather_hit;
      end
      rnop_pkg::ST_E_LIST, rnop_pkg::ST_P_LIST: begin
        lst_re = 1'b1;
      end
      rnop_pkg::ST_E_TAB, rnop_pkg::ST_P_TAB: begin
        tbl_re = 1'b1;
        tbl_ra = lst_rd;
      end
      rnop_pkg::ST_P_ACT: begin
        tbl_we = 1'b1;
        tbl_wa = oidx_r;
        tbl_wd = o_new;
      end
      rnop_pkg::ST_WB: begin
        tbl_we = 1'b1;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rnop_pkg::ST_IDLE;
      strict_r    <= 1'b0;
      count_r     <= NW'(rnop_pkg::MAX_BOXES);
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == rnop_pkg::CFG_STRICT) strict_r <= cfg_data[0];
        else count_r <= cfg_data[NW-1:0];
      end
      if (state_r == rnop_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      chk_v_r <= (state_r == rnop_pkg::ST_GATHER) && (k_r < used);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      rnop_pkg::ST_IDLE: begin
        if (accept) begin
          idx_r   <= in_data.box_index;
          prop_r  <= (in_data.func == rnop_pkg::FUNC_PROP) &&
                     ({1'b0, in_data.box_index} < used);
          fail_r  <= 1'b0;
          bbox_r  <= in_box;
          k_r     <= '0;
          total_r <= '0;
        end
      end
      rnop_pkg::ST_LATCH: bbox_r <= tbl_rd;
      rnop_pkg::ST_GATHER: begin
        if (k_r < used) k_r <= k_r + NW'(1);
        chk_k_r <= k_r[IW-1:0];
        if (gather_hit) total_r <= total_r + NW'(1);
      end
      rnop_pkg::ST_E_INIT: begin
        lx_r   <= bbox_r.xl;
        ly_r   <= bbox_r.yl;
        hx_r   <= {1'b0, bbox_r.xh} + {1'b0, bbox_r.wh};
        hy_r   <= {1'b0, bbox_r.yh} + {1'b0, bbox_r.hh};
        area_r <= bbox_r.wl * bbox_r.hl;
        k_r    <= '0;
      end
      rnop_pkg::ST_E_SUM: sum_r <= SB'(area_r);
      rnop_pkg::ST_E_UPD: begin
        if (o_rd.xl < lx_r) lx_r <= o_rd.xl;
        if (o_rd.yl < ly_r) ly_r <= o_rd.yl;
        if (o_hx > hx_r) hx_r <= o_hx;
        if (o_hy > hy_r) hy_r <= o_hy;
        area_r <= o_rd.wl * o_rd.hl;
      end
      rnop_pkg::ST_E_MUL: begin
        sum_r  <= sum_r + SB'(area_r);
        prod_r <= dx * dy;
      end
      rnop_pkg::ST_E_CMP: begin
        if ($signed({1'b0, sum_r}) > SB'(prod_r) + (SB+1)'(0)) fail_r <= 1'b1;
        else k_r <= last_nb ? '0 : k_r + NW'(1);
      end
      rnop_pkg::ST_P_TAB: oidx_r <= lst_rd;
      rnop_pkg::ST_P_ACT: begin
        bbox_r <= b_new;
        if (!push_ok) fail_r <= 1'b1;
        k_r <= k_r + NW'(1);
      end
      rnop_pkg::ST_DONE: begin
        if (out_free) begin
          out_r <= '{failed: fail_r,
                     out_x_lo: bbox_r.xl, out_x_hi: bbox_r.xh,
                     out_w_lo: bbox_r.wl, out_w_hi: bbox_r.wh,
                     out_y_lo: bbox_r.yl, out_y_hi: bbox_r.yh,
                     out_h_lo: bbox_r.hl, out_h_hi: bbox_r.hh};
        end
      end
      default: begin
        fail_r <= fail_r;
      end
    endcase
  end

endmodule

@@ design/rnop_ram.sv @@
// Generic one-write one-read synchronous RAM, registered read data.
// No dependencies.
module rnop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ design/rnop_push.sv @@
// Push rule between the propagated box and one neighbor.
// Uses rnop_pkg types and direction codes.
module rnop_push (
  input  rnop_pkg::box_t b_box,
  input  rnop_pkg::box_t o_box,
  output rnop_pkg::box_t b_new,
  output rnop_pkg::box_t o_new,
  output logic           ok
);

  localparam int SW = rnop_pkg::COORD_BITS + 2;

  // p lies before q on the axis: raise q's origin, shrink p's origin and size
  function automatic rnop_pkg::ax_res_t push_axis(rnop_pkg::axis_t p, rnop_pkg::axis_t q);
    logic signed [SW-1:0] v1, v2, v3;
    rnop_pkg::ax_res_t r;
    v1 = $signed({2'b00, p.pl}) + $signed({2'b00, p.sl});
    v2 = $signed({2'b00, q.ph}) - $signed({2'b00, p.sl});
    v3 = $signed({2'b00, q.ph}) - $signed({2'b00, p.pl});
    r.p = p;
    r.q = q;
    r.ok = 1'b1;
    if (v1 > $signed({2'b00, q.ph})) begin
      r.ok = 1'b0;
    end else begin
      if (v1 > $signed({2'b00, q.pl})) r.q.pl = v1[rnop_pkg::COORD_BITS-1:0];
      if (v2 < $signed({2'b00, p.pl})) begin
        r.ok = 1'b0;
      end else begin
        if (v2 < $signed({2'b00, p.ph})) r.p.ph = v2[rnop_pkg::COORD_BITS-1:0];
        if (v3 < $signed({2'b00, p.sl})) begin
          r.ok = 1'b0;
        end else if (v3 < $signed({2'b00, p.sh})) begin
          r.p.sh = v3[rnop_pkg::COORD_BITS-1:0];
        end
      end
    end
    return r;
  endfunction

  rnop_pkg::axis_t bx, by, ox, oy;
  rnop_pkg::ax_res_t res;
  logic [3:0] dir;

  assign bx = '{pl: b_box.xl, ph: b_box.xh, sl: b_box.wl, sh: b_box.wh};
  assign by = '{pl: b_box.yl, ph: b_box.yh, sl: b_box.hl, sh: b_box.hh};
  assign ox = '{pl: o_box.xl, ph: o_box.xh, sl: o_box.wl, sh: o_box.wh};
  assign oy = '{pl: o_box.yl, ph: o_box.yh, sl: o_box.hl, sh: o_box.hh};

  assign dir[0] = ({1'b0, b_box.xl} + {1'b0, b_box.wl}) <= {1'b0, o_box.xh};
  assign dir[1] = ({1'b0, o_box.xl} + {1'b0, o_box.wl}) <= {1'b0, b_box.xh};
  assign dir[2] = ({1'b0, b_box.yl} + {1'b0, b_box.hl}) <= {1'b0, o_box.yh};
  assign dir[3] = ({1'b0, o_box.yl} + {1'b0, o_box.hl}) <= {1'b0, b_box.yh};

  always_comb begin
    b_new = b_box;
    o_new = o_box;
    ok    = 1'b1;
    res   = '0;
    case (dir)
      rnop_pkg::DIR_NONE: begin
        ok = 1'b0;
      end
      rnop_pkg::DIR_LEFT: begin
        res = push_axis(bx, ox);
        {b_new.xl, b_new.xh, b_new.wl, b_new.wh} = res.p;
        {o_new.xl, o_new.xh, o_new.wl, o_new.wh} = res.q;
        ok = res.ok;
      end
      rnop_pkg::DIR_RIGHT: begin
        res = push_axis(ox, bx);
        {o_new.xl, o_new.xh, o_new.wl, o_new.wh} = res.p;
        {b_new.xl, b_new.xh, b_new.wl, b_new.wh} = res.q;
        ok = res.ok;
      end
      rnop_pkg::DIR_BELOW: begin
        res = push_axis(by, oy);
        {b_new.yl, b_new.yh, b_new.hl, b_new.hh} = res.p;
        {o_new.yl, o_new.yh, o_new.hl, o_new.hh} = res.q;
        ok = res.ok;
      end
      rnop_pkg::DIR_ABOVE: begin
        res = push_axis(oy, by);
        {o_new.yl, o_new.yh, o_new.hl, o_new.hh} = res.p;
        {b_new.yl, b_new.yh, b_new.hl, b_new.hh} = res.q;
        ok = res.ok;
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

endmodule

@@ design/rnop_checker.sv @@
// Port-level checks of the rectangle non-overlap propagator, bound to the top.
// Uses rnop_pkg and the assertion macros header.
`include "rect_non_overlap_propagator_core_defines.svh"

module rnop_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rnop_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rnop_pkg::out_rsp_t out_data
);

  logic load_acc, read_acc;

  assign load_acc = in_valid && !in_stall && !out_valid &&
                    (in_data.func == rnop_pkg::FUNC_LOAD);
  assign read_acc = in_valid && !in_stall && !out_valid &&
                    (in_data.func == rnop_pkg::FUNC_READ);

  `RNOP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `RNOP_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `RNOP_ASSERT(a_load_result, load_acc |-> ##2 (out_valid && !out_data.failed))
  `RNOP_ASSERT_NEXT(a_read_result, read_acc, ##2 (out_valid && !out_data.failed))

endmodule

bind rect_non_overlap_propagator_core rnop_port_checker u_rnop_port_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ sim/rnop_checker.sv @@
// Checker for the rectangle non-overlap propagator: watches the request,
// result and register channels, predicts each result and compares. Uses rnop_pkg.
module rnop_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rnop_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rnop_pkg::out_rsp_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint xl, xh, wl, wh, yl, yh, hl, hh;
  } rect_t;

  rect_t    boxes[rnop_pkg::MAX_BOXES];
  int       nbr[rnop_pkg::MAX_BOXES];
  int       nbr_cnt;
  bit       strict_q;
  int       count_q;
  rnop_pkg::out_rsp_t expected_rsp[$];

  function automatic bit apart_x(rect_t a, rect_t b);
    return a.xl >= b.xh + b.wh || b.xl >= a.xh + a.wh ||
           (!strict_q && (a.wl == 0 || b.wl == 0));
  endfunction

  function automatic bit apart_y(rect_t a, rect_t b);
    return a.yl >= b.yh + b.hh || b.yl >= a.yh + a.hh ||
           (!strict_q && (a.hl == 0 || b.hl == 0));
  endfunction

  function automatic bit raise_min(ref longint lo, input longint hi, input longint v);
    if (v > hi) return 0;
    if (v > lo) lo = v;
    return 1;
  endfunction

  function automatic bit lower_max(input longint lo, ref longint hi, input longint v);
    if (v < lo) return 0;
    if (v < hi) hi = v;
    return 1;
  endfunction

  function automatic bit push_pair(ref rect_t b, ref rect_t o);
    logic [3:0] dir;
    dir = {o.yl + o.hl <= b.yh, b.yl + b.hl <= o.yh,
           o.xl + o.wl <= b.xh, b.xl + b.wl <= o.xh};
    case (dir)
      rnop_pkg::DIR_NONE:  return 0;
      rnop_pkg::DIR_LEFT:  return raise_min(o.xl, o.xh, b.xl + b.wl) &&
                                  lower_max(b.xl, b.xh, o.xh - b.wl) &&
                                  lower_max(b.wl, b.wh, o.xh - b.xl);
      rnop_pkg::DIR_RIGHT: return raise_min(b.xl, b.xh, o.xl + o.wl) &&
                                  lower_max(o.xl, o.xh, b.xh - o.wl) &&
                                  lower_max(o.wl, o.wh, b.xh - o.xl);
      rnop_pkg::DIR_BELOW: return raise_min(o.yl, o.yh, b.yl + b.hl) &&
                                  lower_max(b.yl, b.yh, o.yh - b.hl) &&
                                  lower_max(b.hl, b.hh, o.yh - b.yl);
      rnop_pkg::DIR_ABOVE: return raise_min(b.yl, b.yh, o.yl + o.hl) &&
                                  lower_max(o.yl, o.yh, b.yh - o.hl) &&
                                  lower_max(o.hl, o.hh, b.yh - o.yl);
      default:             return 1;
    endcase
  endfunction

  function automatic bit propagate_box(int b);
    longint lx, hx, ly, hy, area;
    rect_t  r, o;
    nbr_cnt = 0;
    for (int k = 0; k < count_q; k++)
      if (k != b && !apart_x(boxes[k], boxes[b]) && !apart_y(boxes[k], boxes[b])) begin
        nbr[nbr_cnt] = k;
        nbr_cnt++;
      end
    r = boxes[b];
    lx = r.xl; hx = r.xh + r.wh; ly = r.yl; hy = r.yh + r.hh;
    area = r.wl * r.hl;
    for (int k = 0; k < nbr_cnt; k++) begin
      o = boxes[nbr[k]];
      if (o.xl < lx) lx = o.xl;
      if (o.xh + o.wh > hx) hx = o.xh + o.wh;
      if (o.yl < ly) ly = o.yl;
      if (o.yh + o.hh > hy) hy = o.yh + o.hh;
      area += o.wl * o.hl;
      if (area > (hx - lx) * (hy - ly)) return 0;
    end
    for (int k = 0; k < nbr_cnt; k++)
      if (!push_pair(boxes[b], boxes[nbr[k]])) return 0;
    return 1;
  endfunction

  function automatic rnop_pkg::out_rsp_t predict_rsp(rnop_pkg::in_req_t rq);
    rnop_pkg::out_rsp_t rs;
    int       b;
    b = int'(rq.box_index);
    rs = '0;
    if (rq.func == rnop_pkg::FUNC_LOAD) begin
      boxes[b] = '{rq.in_x_lo, rq.in_x_hi, rq.in_w_lo, rq.in_w_hi,
                   rq.in_y_lo, rq.in_y_hi, rq.in_h_lo, rq.in_h_hi};
    end else if (rq.func == rnop_pkg::FUNC_PROP && b < count_q) begin
      rs.failed = !propagate_box(b);
    end
    rs.out_x_lo = boxes[b].xl[15:0]; rs.out_x_hi = boxes[b].xh[15:0];
    rs.out_w_lo = boxes[b].wl[15:0]; rs.out_w_hi = boxes[b].wh[15:0];
    rs.out_y_lo = boxes[b].yl[15:0]; rs.out_y_hi = boxes[b].yh[15:0];
    rs.out_h_lo = boxes[b].hl[15:0]; rs.out_h_hi = boxes[b].hh[15:0];
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    strict_q = 0;
    count_q = rnop_pkg::MAX_BOXES;
    nbr_cnt = 0;
    foreach (boxes[i]) boxes[i] = '{0, 0, 0, 0, 0, 0, 0, 0};
  end

  always @(posedge clk) begin
    rnop_pkg::out_rsp_t want;
    if (!rst_n) begin
      strict_q = 0;
      count_q = rnop_pkg::MAX_BOXES;
      expected_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rnop_pkg::CFG_STRICT) strict_q = cfg_data[0];
        else count_q = (cfg_data > rnop_pkg::MAX_BOXES) ? rnop_pkg::MAX_BOXES
                                                         : int'(cfg_data);
      end
      if (in_valid && !in_stall)
        expected_rsp.insert(expected_rsp.size(), predict_rsp(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with none pending", out_data.out_x_lo, 16'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.failed != want.failed)
            report_mismatch("failed", {15'd0, out_data.failed}, {15'd0, want.failed});
          if (out_data.out_x_lo != want.out_x_lo)
            report_mismatch("x_lo", out_data.out_x_lo, want.out_x_lo);
          if (out_data.out_x_hi != want.out_x_hi)
            report_mismatch("x_hi", out_data.out_x_hi, want.out_x_hi);
          if (out_data.out_w_lo != want.out_w_lo)
            report_mismatch("w_lo", out_data.out_w_lo, want.out_w_lo);
          if (out_data.out_w_hi != want.out_w_hi)
            report_mismatch("w_hi", out_data.out_w_hi, want.out_w_hi);
          if (out_data.out_y_lo != want.out_y_lo)
            report_mismatch("y_lo", out_data.out_y_lo, want.out_y_lo);
          if (out_data.out_y_hi != want.out_y_hi)
            report_mismatch("y_hi", out_data.out_y_hi, want.out_y_hi);
          if (out_data.out_h_lo != want.out_h_lo)
            report_mismatch("h_lo", out_data.out_h_lo, want.out_h_lo);
          if (out_data.out_h_hi != want.out_h_hi)
            report_mismatch("h_hi", out_data.out_h_hi, want.out_h_hi);
        end
      end
    end
    pending = expected_rsp.size();
  end
endmodule

@@ sim/tb.sv @@
// Top of the propagator testbench: drives requests, register writes and
// result stalls, and gives the verdict. Uses rnop_pkg and rnop_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  rnop_pkg::in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  rnop_pkg::out_rsp_t out_data;
  logic     cfg_valid = 0;
  logic     cfg_ready;
  logic     cfg_index = rnop_pkg::CFG_STRICT;
  logic [6:0] cfg_data = '0;
  int       mismatches, pending;
  longint   cycles = 0;
  bit       loaded[rnop_pkg::MAX_BOXES];

  always #2 clk = ~clk;

  rect_non_overlap_propagator_core dut (.*);
  rnop_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd6000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side stalls at random, with calm stretches
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (n) begin
        @(posedge clk);
        out_stall <= 1;
      end
      @(posedge clk);
      out_stall <= 0;
    end
  end

  // valid stays up into the next request when there is no gap
  task automatic send_req(rnop_pkg::in_req_t rq);
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    if (rq.func == rnop_pkg::FUNC_LOAD) loaded[rq.box_index] = 1;
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [15:0] rand_coord(int span);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, span));
    endcase
  endfunction

  function automatic rnop_pkg::in_req_t load_req(int b, int span);
    rnop_pkg::in_req_t rq;
    logic [15:0] a, c;
    rq.func = rnop_pkg::FUNC_LOAD;
    rq.box_index = 6'(b);
    a = rand_coord(span); c = rand_coord(span);
    {rq.in_x_lo, rq.in_x_hi} = ($urandom_range(0, 9) == 0) ? {c, a} :
                               (a < c ? {a, c} : {c, a});
    a = rand_coord(span / 4); c = rand_coord(span / 4);
    {rq.in_w_lo, rq.in_w_hi} = a < c ? {a, c} : {c, a};
    a = rand_coord(span); c = rand_coord(span);
    {rq.in_y_lo, rq.in_y_hi} = ($urandom_range(0, 9) == 0) ? {c, a} :
                               (a < c ? {a, c} : {c, a});
    a = rand_coord(span / 4); c = rand_coord(span / 4);
    {rq.in_h_lo, rq.in_h_hi} = a < c ? {a, c} : {c, a};
    return rq;
  endfunction

  // propagate may pick any index; read only boxes that were loaded: every box in use must be loaded
  function automatic rnop_pkg::in_req_t pick_req(int nb);
    rnop_pkg::in_req_t rq;
    int r;
    rq = '0;
    {rq.in_x_lo, rq.in_x_hi, rq.in_w_lo, rq.in_w_hi} = {$urandom, $urandom};
    {rq.in_y_lo, rq.in_y_hi, rq.in_h_lo, rq.in_h_hi} = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    rq.box_index = 6'($urandom_range(0, rnop_pkg::MAX_BOXES - 1));
    if (r < 3) begin
      rq = load_req($urandom_range(0, nb - 1), ($urandom_range(0, 1)) ? 200 : 65535);
    end else if (r < 8) begin
      rq.func = rnop_pkg::FUNC_PROP;
      rq.box_index = 6'($urandom_range(0, rnop_pkg::MAX_BOXES - 1));
    end else begin
      rq.func = (r == 8) ? rnop_pkg::FUNC_READ : rnop_pkg::FUNC_RSVD;
      while (!loaded[rq.box_index])
        rq.box_index = 6'($urandom_range(0, rnop_pkg::MAX_BOXES - 1));
    end
    return rq;
  endfunction

  initial begin
    rnop_pkg::in_req_t rq;
    int nb;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed: load every table entry so any box count is safe
    for (int b = 0; b < rnop_pkg::MAX_BOXES; b++) begin
      rq = load_req(b, 300);
      if (b == 0) {rq.in_x_lo, rq.in_x_hi, rq.in_w_lo, rq.in_w_hi,
                   rq.in_y_lo, rq.in_y_hi, rq.in_h_lo, rq.in_h_hi} = '1;
      if (b == 1) {rq.in_x_lo, rq.in_x_hi, rq.in_w_lo, rq.in_w_hi,
                   rq.in_y_lo, rq.in_y_hi, rq.in_h_lo, rq.in_h_hi} = '0;
      send_req(rq);
    end
    rq = '0; rq.func = rnop_pkg::FUNC_READ; rq.box_index = 0; send_req(rq);
    rq.func = rnop_pkg::FUNC_RSVD; rq.box_index = 63; send_req(rq);
    rq.func = rnop_pkg::FUNC_PROP; rq.box_index = 63; send_req(rq);
    rq.box_index = 2; send_req(rq);
    write_reg(rnop_pkg::CFG_STRICT, 7'd1);
    rq.box_index = 1; send_req(rq);
    write_reg(rnop_pkg::CFG_COUNT, 7'd1);
    rq.box_index = 0; send_req(rq);
    rq.box_index = 5; send_req(rq);
    write_reg(rnop_pkg::CFG_COUNT, 7'd0);
    rq.box_index = 0; send_req(rq);
    write_reg(rnop_pkg::CFG_COUNT, 7'd127);
    rq.box_index = 10; send_req(rq);
    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(rnop_pkg::CFG_STRICT, 7'($urandom_range(0, 1)));
      case (ph % 4)
        0: nb = 2;
        1: nb = $urandom_range(3, 8);
        2: nb = $urandom_range(8, 16);
        default: nb = (ph == 11) ? 64 : $urandom_range(3, 12);
      endcase
      write_reg(rnop_pkg::CFG_COUNT, (ph == 7) ? 7'd100 : nb[6:0]);
      for (int b = 0; b < nb; b++) send_req(load_req(b, 100 + 40 * nb));
      for (int i = 0; i < 150; i++) send_req(pick_req(nb));
    end
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/rnop_pkg.sv
design/rnop_ram.sv
design/rnop_push.sv
design/rect_non_overlap_propagator_core.sv
design/rnop_checker.sv
sim/rnop_checker.sv
sim/tb.sv
